// File: rtl/core/ddo_pkg.sv
// Shared types, constants and helper functions of the odometry and go-to-point block.
package ddo_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN  = 3'd5;

	// Register reset values
	localparam logic [31:0] RST_TARGET_X   = 32'd26214;
	localparam logic [31:0] RST_TARGET_Y   = 32'd0;
	localparam logic [31:0] RST_TICK_SCALE = 32'd365072;
	localparam logic [31:0] RST_WHEEL_BASE = 32'd15073;
	localparam logic [15:0] RST_DRIVE_GAIN = 16'd500;
	localparam logic [15:0] RST_TURN_GAIN  = 16'd1;

	// Datapath widths
	localparam int MUL_W    = 34;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int DIVD_W   = 64;
	localparam int DIVS_W   = 34;
	localparam int DIV_CNT_W = $clog2(DIVD_W);
	localparam int XY_W     = 46;
	localparam int ANG_W    = 21;
	localparam int HEAD_W   = 20;
	localparam int SC_W     = 18;
	localparam int IDX_W    = 5;
	localparam int SAT_W    = 72;

	// Fixed-point constants
	localparam logic signed [MUL_W-1:0] ANG_K     = 34'sd749613;
	localparam logic signed [ANG_W-1:0] PI_Q      = 21'sd205887;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q = 21'sd102944;
	localparam logic signed [XY_W-1:0]  CORDIC_X0 = 46'sd652032874;
	localparam logic [IDX_W-1:0]        CORDIC_LAST = 5'd16;
	localparam logic signed [XY_W-1:0]  NORM_LIMIT = 46'sd1099511627776;
	localparam int                      SC_SHIFT  = 14;
	localparam logic [ANG_W-1:0]        TH_ALIGN  = 21'd13107;
	localparam logic [ANG_W-1:0]        TH_FINE   = 21'd655;
	localparam logic [MUL_W-1:0]        TH_FINE_POS = 34'd655;
	localparam logic signed [SAT_W-1:0] ROT_BIAS  = 72'sd6554;
	localparam logic signed [PROD_W-1:0] SPEED_BIAS = 68'sd983040;
	localparam logic signed [35:0]      SPEED_CAP   = 36'sd500;
	localparam logic signed [35:0]      SPEED_FLOOR = -36'sd32768;
	localparam logic signed [6:0]       ARC_RADIUS  = 7'sd50;
	localparam logic signed [SAT_W-1:0] SAT_MAX = 72'sd2147483647;
	localparam logic signed [SAT_W-1:0] SAT_MIN = -72'sd2147483648;

	// CORDIC control word
	typedef struct packed {
		logic start;
		logic vec_mode;
	} cordic_ctl_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_REDUCE,
		C_NORM,
		C_ITER,
		C_DONE
	} cor_state_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MUL_L,
		S_MUL_R,
		S_MUL_G,
		S_RADS,
		S_SC_NOW,
		S_SC_NOW_W,
		S_SC_OLD,
		S_SC_OLD_W,
		S_ARC_MUL,
		S_ARC_DIV,
		S_ARC_DIV_W,
		S_ARC_MX,
		S_ARC_MY,
		S_STR_MX,
		S_STR_MY,
		S_POS_Y,
		S_TARGET,
		S_BEARING,
		S_BEARING_W,
		S_ERR,
		S_SPEED_MUL,
		S_ROT_MUL,
		S_ROT,
		S_FIN
	} seq_state_t;

	// Arctangent of 2^-i, Q16.16 radians
	function automatic logic [16:0] atan_entry(input logic [IDX_W-1:0] i);
		logic [16:0] v;
		case (i)
			5'd0:  v = 17'd51472;
			5'd1:  v = 17'd30386;
			5'd2:  v = 17'd16055;
			5'd3:  v = 17'd8150;
			5'd4:  v = 17'd4091;
			5'd5:  v = 17'd2047;
			5'd6:  v = 17'd1024;
			5'd7:  v = 17'd512;
			5'd8:  v = 17'd256;
			5'd9:  v = 17'd128;
			5'd10: v = 17'd64;
			5'd11: v = 17'd32;
			5'd12: v = 17'd16;
			5'd13: v = 17'd8;
			5'd14: v = 17'd4;
			5'd15: v = 17'd2;
			5'd16: v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// Clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX)
			r = 32'sh7fffffff;
		else if (v < SAT_MIN)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// File: rtl/core/ddo_mul.sv
// Shared signed multiplier with a registered product.
module ddo_mul (
	input  logic                              clk,
	input  logic signed [ddo_pkg::MUL_W-1:0]  a,
	input  logic signed [ddo_pkg::MUL_W-1:0]  b,
	output logic signed [ddo_pkg::PROD_W-1:0] prod
);
	import ddo_pkg::*;

	// Register the product for the next state
	always_ff @(posedge clk) begin
		prod <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// File: rtl/core/ddo_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ddo_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ddo_pkg::DIVD_W-1:0]       dividend,
	input  logic [ddo_pkg::DIVS_W-1:0]       divisor,
	output logic                             done,
	output logic [ddo_pkg::DIVD_W-1:0]       quotient
);
	import ddo_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVS_W-1:0]    rem_q;
	logic [DIVS_W-1:0]    dvs_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DIVS_W:0]      trial;
	logic [DIVS_W:0]      trial_sub;
	logic                 ge;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		trial     = {rem_q, quo_q[DIVD_W-1]};
		trial_sub = trial - {1'b0, dvs_q};
		ge        = trial >= {1'b0, dvs_q};
	end

	// Control: run for one step per dividend bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/core/ddo_cordic.sv
// Iterative CORDIC: sine and cosine by rotation, arctangent by vectoring.
module ddo_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ddo_pkg::cordic_ctl_t              ctl,
	input  logic signed [ddo_pkg::HEAD_W-1:0] angle,
	input  logic signed [ddo_pkg::XY_W-1:0]   vx,
	input  logic signed [ddo_pkg::XY_W-1:0]   vy,
	output logic                              done,
	output logic signed [ddo_pkg::SC_W-1:0]   sin_val,
	output logic signed [ddo_pkg::SC_W-1:0]   cos_val,
	output logic signed [ddo_pkg::ANG_W-1:0]  atan_val
);
	import ddo_pkg::*;

	cor_state_t              state_q, state_d;
	logic signed [XY_W-1:0]  x_q, y_q;
	logic signed [ANG_W-1:0] acc_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    vec_q;
	logic                    neg_q;

	logic signed [XY_W-1:0]  xs, ys, ay, mag, xr, yr;
	logic signed [ANG_W-1:0] tab;
	logic                    dir, same, need_norm, above, below;

	// Micro-rotation and helper terms
	always_comb begin
		xs        = x_q >>> idx_q;
		ys        = y_q >>> idx_q;
		tab       = $signed({4'b0000, atan_entry(idx_q)});
		dir       = vec_q ? ~y_q[XY_W-1] : ~acc_q[ANG_W-1];
		same      = (!vec_q) == dir;
		ay        = y_q[XY_W-1] ? -y_q : y_q;
		mag       = (x_q > ay) ? x_q : ay;
		need_norm = mag < NORM_LIMIT;
		above     = acc_q > HALF_PI_Q;
		below     = acc_q < -HALF_PI_Q;
		xr        = x_q >>> SC_SHIFT;
		yr        = y_q >>> SC_SHIFT;
	end

	// Next state and done strobe
	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		unique case (state_q)
			C_IDLE: begin
				if (ctl.start)
					state_d = ctl.vec_mode ? C_NORM : C_REDUCE;
			end
			C_REDUCE: begin
				if (!above && !below)
					state_d = C_ITER;
			end
			C_NORM: begin
				if (!need_norm)
					state_d = C_ITER;
			end
			C_ITER: begin
				if (idx_q == CORDIC_LAST)
					state_d = C_DONE;
			end
			C_DONE: begin
				done    = 1'b1;
				state_d = C_IDLE;
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= C_IDLE;
		else
			state_q <= state_d;
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (ctl.start) begin
					vec_q <= ctl.vec_mode;
					neg_q <= 1'b0;
					idx_q <= '0;
					x_q   <= ctl.vec_mode ? vx : CORDIC_X0;
					y_q   <= ctl.vec_mode ? vy : '0;
					acc_q <= ctl.vec_mode ? '0 : ANG_W'(angle);
				end
			end
			C_REDUCE: begin
				// fold the angle into the right half plane
				if (above) begin
					acc_q <= acc_q - PI_Q;
					neg_q <= ~neg_q;
				end else if (below) begin
					acc_q <= acc_q + PI_Q;
					neg_q <= ~neg_q;
				end
			end
			C_NORM: begin
				if (need_norm) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			C_ITER: begin
				x_q   <= same ? x_q - ys : x_q + ys;
				y_q   <= same ? y_q + xs : y_q - xs;
				acc_q <= same ? acc_q - tab : acc_q + tab;
				idx_q <= idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign sin_val  = neg_q ? -yr[SC_W-1:0] : yr[SC_W-1:0];
	assign cos_val  = neg_q ? -xr[SC_W-1:0] : xr[SC_W-1:0];
	assign atan_val = acc_q;

endmodule

// File: rtl/core/diff_drive_odometry_goto.sv
// Top level: odometry update, bearing and go-to-point command per encoder word.
// Each accepted word carries two wheel counts and a gyro heading. Every fifth word, the first
// one after reset included, is consumed in the idle state and yields no result. Any other
// word is worked through by a sequencer over one shared multiplier, one iterative CORDIC (17
// steps plus range folding or normalisation) and one 64-step restoring divider. in_ready
// stays low while a word is at work, and a finished result that cannot enter the occupied
// output register holds it low longer. A finished result waits in the output register, and
// the next word is taken meanwhile. Configuration writes are accepted in any cycle, one per
// cycle.
module diff_drive_odometry_goto (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [15:0]                         enc_left,
	input  logic [15:0]                         enc_right,
	input  logic signed [15:0]                  gyro_angle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [31:0]                  pos_x,
	output logic signed [31:0]                  pos_y,
	output logic signed [31:0]                  heading_error,
	output logic                                command_kind,
	output logic signed [15:0]                  drive_speed,
	output logic signed [6:0]                   turn_radius,
	output logic signed [31:0]                  rotation_speed,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ddo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                         cfg_data
);
	import ddo_pkg::*;

	// Configuration registers
	logic signed [31:0] target_x_q, target_y_q;
	logic [31:0]        tick_scale_q, wheel_base_q;
	logic [15:0]        drive_gain_q, turn_gain_q;

	// Odometry state
	logic [15:0]              last_left_q, last_right_q;
	logic                     started_q;
	logic [2:0]               phase_q;
	logic signed [HEAD_W-1:0] last_head_q;
	logic signed [31:0]       est_x_q, est_y_q;
	logic                     aligned_q;

	// Working registers
	seq_state_t               state_q, state_d;
	logic signed [15:0]       dl_q, dr_q, gyro_q;
	logic signed [MUL_W-1:0]  l_q, r_q;
	logic signed [HEAD_W-1:0] rads_q;
	logic signed [SC_W-1:0]   sn_q, cn_q, sp_q, cp_q;
	logic                     arc_q;
	logic                     div_neg_q;
	logic signed [31:0]       rad_q;
	logic signed [32:0]       dx_q, dy_q;
	logic signed [ANG_W-1:0]  fi_q, efi_q;
	logic signed [MUL_W-1:0]  epos_q;
	logic signed [35:0]       trans_q;
	logic signed [31:0]       rot_q;

	// Output register
	logic               out_valid_q;
	logic signed [31:0] pos_x_q, pos_y_q, herr_q, rot_out_q;
	logic               kind_q;
	logic signed [15:0] speed_q;
	logic signed [6:0]  radius_q;

	// Shared units
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod, prod_sh, prod_abs, speed_v;
	cordic_ctl_t              cor_ctl;
	logic signed [HEAD_W-1:0] cor_angle;
	logic signed [XY_W-1:0]   cor_vx, cor_vy;
	logic                     cor_done;
	logic signed [SC_W-1:0]   cor_sin, cor_cos;
	logic signed [ANG_W-1:0]  cor_atan;
	logic                     div_start, div_done;
	logic [DIVD_W-1:0]        div_quo;

	// Derived terms
	logic                     in_acc, out_load;
	logic signed [34:0]       rl_sum, rl_diff, diff_abs;
	logic signed [31:0]       sum32;
	logic [DIVS_W-1:0]        divisor;
	logic signed [18:0]       dsn, dcs;
	logic signed [32:0]       dx_abs, vy_dir;
	logic signed [31:0]       rad_new;
	logic signed [35:0]       trans_new;
	logic signed [ANG_W-1:0]  afi;
	logic [MUL_W-1:0]         aepos;
	logic                     drive;
	logic signed [15:0]       speed_new;
	logic signed [6:0]        radius_new;

	ddo_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	ddo_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (cor_ctl),
		.angle    (cor_angle),
		.vx       (cor_vx),
		.vy       (cor_vy),
		.done     (cor_done),
		.sin_val  (cor_sin),
		.cos_val  (cor_cos),
		.atan_val (cor_atan)
	);

	ddo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_abs[DIVD_W-1:0]),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Combinational arithmetic around the shared units
	always_comb begin
		prod_sh  = prod >>> 16;
		prod_abs = prod[PROD_W-1] ? -prod : prod;
		rl_sum   = 35'(l_q) + 35'(r_q);
		rl_diff  = 35'(r_q) - 35'(l_q);
		diff_abs = rl_diff[34] ? -rl_diff : rl_diff;
		divisor  = {diff_abs[DIVS_W-2:0], 1'b0};
		sum32    = sat32(SAT_W'(rl_sum));
		dsn      = 19'(sn_q) - 19'(sp_q);
		dcs      = 19'(cn_q) - 19'(cp_q);
		dx_abs   = dx_q[32] ? -dx_q : dx_q;
		vy_dir   = dx_q[32] ? -dy_q : dy_q;
		cor_vx   = XY_W'(dx_abs);
		cor_vy   = XY_W'(vy_dir);
		cor_angle = (state_q == S_SC_OLD) ? last_head_q : rads_q;
		// quotient sign and clamp
		if (div_neg_q)
			rad_new = (div_quo > DIVD_W'(64'h80000000)) ? 32'sh80000000 : -div_quo[31:0];
		else
			rad_new = (div_quo > DIVD_W'(64'h7fffffff)) ? 32'sh7fffffff : div_quo[31:0];
		// speed with truncation toward zero
		speed_v   = prod + SPEED_BIAS;
		trans_new = speed_v[51:16] +
			36'((speed_v[PROD_W-1] && (speed_v[15:0] != 16'd0)) ? 1 : 0);
		// controller decisions
		afi   = efi_q[ANG_W-1] ? -efi_q : efi_q;
		aepos = epos_q[MUL_W-1] ? -epos_q : epos_q;
		drive = (afi < TH_ALIGN) && aligned_q;
		if (aepos < TH_FINE_POS)
			speed_new = '0;
		else if (trans_q > SPEED_CAP)
			speed_new = SPEED_CAP[15:0];
		else if (trans_q < SPEED_FLOOR)
			speed_new = SPEED_FLOOR[15:0];
		else
			speed_new = trans_q[15:0];
		if (afi < TH_FINE)
			radius_new = '0;
		else
			radius_new = (efi_q > 0) ? ARC_RADIUS : -ARC_RADIUS;
	end

	// Sequencer: next state and unit controls
	always_comb begin
		state_d          = state_q;
		mul_a            = '0;
		mul_b            = '0;
		cor_ctl.start    = 1'b0;
		cor_ctl.vec_mode = 1'b0;
		div_start        = 1'b0;
		out_load         = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && (phase_q != 3'd0))
					state_d = S_MUL_L;
			end
			S_MUL_L: begin
				mul_a   = MUL_W'(dl_q);
				mul_b   = $signed({2'b00, tick_scale_q});
				state_d = S_MUL_R;
			end
			S_MUL_R: begin
				mul_a   = MUL_W'(dr_q);
				mul_b   = $signed({2'b00, tick_scale_q});
				state_d = S_MUL_G;
			end
			S_MUL_G: begin
				mul_a   = MUL_W'(gyro_q);
				mul_b   = ANG_K;
				state_d = S_RADS;
			end
			S_RADS: state_d = S_SC_NOW;
			S_SC_NOW: begin
				cor_ctl.start = 1'b1;
				state_d       = S_SC_NOW_W;
			end
			S_SC_NOW_W: begin
				if (cor_done)
					state_d = (rl_diff != '0) ? S_SC_OLD : S_STR_MX;
			end
			S_SC_OLD: begin
				cor_ctl.start = 1'b1;
				state_d       = S_SC_OLD_W;
			end
			S_SC_OLD_W: begin
				if (cor_done)
					state_d = S_ARC_MUL;
			end
			S_ARC_MUL: begin
				mul_a   = $signed({2'b00, wheel_base_q});
				mul_b   = MUL_W'(sum32);
				state_d = S_ARC_DIV;
			end
			S_ARC_DIV: begin
				div_start = 1'b1;
				state_d   = S_ARC_DIV_W;
			end
			S_ARC_DIV_W: begin
				if (div_done)
					state_d = S_ARC_MX;
			end
			S_ARC_MX: begin
				mul_a   = MUL_W'(rad_q);
				mul_b   = MUL_W'(dsn);
				state_d = S_ARC_MY;
			end
			S_ARC_MY: begin
				mul_a   = MUL_W'(rad_q);
				mul_b   = MUL_W'(dcs);
				state_d = S_POS_Y;
			end
			S_STR_MX: begin
				mul_a   = rl_sum[34:1];
				mul_b   = MUL_W'(cn_q);
				state_d = S_STR_MY;
			end
			S_STR_MY: begin
				mul_a   = rl_sum[34:1];
				mul_b   = MUL_W'(sn_q);
				state_d = S_POS_Y;
			end
			S_POS_Y:  state_d = S_TARGET;
			S_TARGET: state_d = S_BEARING;
			S_BEARING: begin
				if (dx_q != '0) begin
					cor_ctl.start    = 1'b1;
					cor_ctl.vec_mode = 1'b1;
					state_d          = S_BEARING_W;
				end else begin
					state_d = S_ERR;
				end
			end
			S_BEARING_W: begin
				if (cor_done)
					state_d = S_ERR;
			end
			S_ERR: state_d = S_SPEED_MUL;
			S_SPEED_MUL: begin
				mul_a   = $signed({18'd0, drive_gain_q});
				mul_b   = epos_q;
				state_d = S_ROT_MUL;
			end
			S_ROT_MUL: begin
				mul_a   = $signed({18'd0, turn_gain_q});
				mul_b   = MUL_W'(efi_q);
				state_d = S_ROT;
			end
			S_ROT: state_d = S_FIN;
			S_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q   <= RST_TARGET_X;
			target_y_q   <= RST_TARGET_Y;
			tick_scale_q <= RST_TICK_SCALE;
			wheel_base_q <= RST_WHEEL_BASE;
			drive_gain_q <= RST_DRIVE_GAIN;
			turn_gain_q  <= RST_TURN_GAIN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TARGET_X:   target_x_q   <= cfg_data;
				REG_TARGET_Y:   target_y_q   <= cfg_data;
				REG_TICK_SCALE: tick_scale_q <= cfg_data;
				REG_WHEEL_BASE: wheel_base_q <= cfg_data;
				REG_DRIVE_GAIN: drive_gain_q <= cfg_data[15:0];
				REG_TURN_GAIN:  turn_gain_q  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Encoder history: first word loads it, skipped words leave it
	always_ff @(posedge clk) begin
		if (in_acc && (!started_q || (phase_q != 3'd0))) begin
			last_left_q  <= enc_left;
			last_right_q <= enc_right;
		end
	end

	// Control state of the odometry and controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			phase_q     <= 3'd0;
			last_head_q <= '0;
			est_x_q     <= '0;
			est_y_q     <= '0;
			aligned_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				started_q <= 1'b1;
				phase_q   <= (phase_q >= 3'd4) ? 3'd0 : phase_q + 3'd1;
			end
			if (state_q == S_ARC_MY || state_q == S_STR_MY)
				est_x_q <= sat32(SAT_W'(est_x_q) + SAT_W'(prod_sh));
			if (state_q == S_POS_Y) begin
				est_y_q <= arc_q ? sat32(SAT_W'(est_y_q) - SAT_W'(prod_sh))
				                 : sat32(SAT_W'(est_y_q) + SAT_W'(prod_sh));
				last_head_q <= rads_q;
			end
			if (out_load)
				aligned_q <= drive ? 1'b1 : (afi < TH_FINE);
		end
	end

	// Working registers of the sequence
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					dl_q   <= $signed(enc_left - last_left_q);
					dr_q   <= $signed(enc_right - last_right_q);
					gyro_q <= gyro_angle;
				end
			end
			S_MUL_R:    l_q    <= prod_sh[MUL_W-1:0];
			S_MUL_G:    r_q    <= prod_sh[MUL_W-1:0];
			S_RADS:     rads_q <= prod_sh[HEAD_W-1:0];
			S_SC_NOW_W: begin
				if (cor_done) begin
					sn_q  <= cor_sin;
					cn_q  <= cor_cos;
					arc_q <= (rl_diff != '0);
				end
			end
			S_SC_OLD_W: begin
				if (cor_done) begin
					sp_q <= cor_sin;
					cp_q <= cor_cos;
				end
			end
			S_ARC_DIV:   div_neg_q <= prod[PROD_W-1] ^ rl_diff[34];
			S_ARC_DIV_W: begin
				if (div_done)
					rad_q <= rad_new;
			end
			S_TARGET: begin
				dx_q <= 33'(target_x_q) - 33'(est_x_q);
				dy_q <= 33'(target_y_q) - 33'(est_y_q);
			end
			S_BEARING: begin
				if (dx_q == '0)
					fi_q <= (dy_q > 0) ? HALF_PI_Q : -HALF_PI_Q;
			end
			S_BEARING_W: begin
				if (cor_done)
					fi_q <= cor_atan;
			end
			S_ERR: begin
				efi_q  <= fi_q - ANG_W'(rads_q);
				epos_q <= MUL_W'(dx_q) + MUL_W'(dy_q);
			end
			S_ROT_MUL: trans_q <= trans_new;
			S_ROT:     rot_q   <= sat32(SAT_W'(prod) + ROT_BIAS);
			default: begin
			end
		endcase
	end

	// Output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_x_q   <= est_x_q;
			pos_y_q   <= est_y_q;
			herr_q    <= 32'(efi_q);
			kind_q    <= !drive;
			speed_q   <= drive ? speed_new : '0;
			radius_q  <= drive ? radius_new : '0;
			rot_out_q <= drive ? '0 : rot_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pos_x          = pos_x_q;
	assign pos_y          = pos_y_q;
	assign heading_error  = herr_q;
	assign command_kind   = kind_q;
	assign drive_speed    = speed_q;
	assign turn_radius    = radius_q;
	assign rotation_speed = rot_out_q;

endmodule

// File: rtl/core/ddo_checker.sv
// Port-level checks of the odometry block, bound to the top level.
module ddo_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [15:0]                   enc_left,
	input logic [15:0]                   enc_right,
	input logic signed [15:0]            gyro_angle,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [31:0]            pos_x,
	input logic signed [31:0]            pos_y,
	input logic signed [31:0]            heading_error,
	input logic                          command_kind,
	input logic signed [15:0]            drive_speed,
	input logic signed [6:0]             turn_radius,
	input logic signed [31:0]            rotation_speed,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]                   cfg_data
);
	import ddo_pkg::*;

	// A waiting result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before it was taken");

	// An arc drive carries no rotation rate
	a_drive_no_rot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !command_kind |-> rotation_speed == 32'sd0)
		else $error("arc drive word with rotation rate");

	// A rotation carries no speed and no radius
	a_rot_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_kind |-> drive_speed == 16'sd0 && turn_radius == 7'sd0)
		else $error("rotate word with drive speed or radius");

	// Arc drive limits
	a_drive_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !command_kind |-> drive_speed <= 16'sd500 &&
		(turn_radius == 7'sd0 || turn_radius == 7'sd50 || turn_radius == -7'sd50))
		else $error("arc drive word out of range");

endmodule

bind diff_drive_odometry_goto ddo_checker u_ddo_checker (.*);

// File: tb/sv/tb_diff_drive_odometry_goto.sv
// Testbench for the odometry and go-to-point block: directed table, random walks, bit-true predictor.
`timescale 1ns / 100ps

module tb_diff_drive_odometry_goto;
	import ddo_pkg::*;

	localparam int PAUSE_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] herr;
		logic               kind;
		logic signed [15:0] speed;
		logic signed [6:0]  radius;
		logic signed [31:0] rot;
	} command_t;

	typedef struct {
		logic [15:0]        el;
		logic [15:0]        er;
		logic signed [15:0] gy;
		bit                 at_origin;
	} sample_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [15:0] enc_left, enc_right;
	logic signed [15:0] gyro_angle;
	logic signed [31:0] pos_x, pos_y, heading_error, rotation_speed;
	logic command_kind;
	logic signed [15:0] drive_speed;
	logic signed [6:0] turn_radius;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	// Predictor state and register copy
	longint goal_x, goal_y, tick_q32, base_q16, speed_gain, rot_gain;
	logic [15:0] prev_left, prev_right;
	longint prev_head, odo_x, odo_y;
	bit is_aligned, has_started;
	int phase_cnt;

	command_t pending_cmds[$];
	int errors = 0;
	int gap_left = 0;
	int burst_left = 0;
	logic [15:0] walk_l, walk_r;

	longint atan_q[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
		128, 64, 32, 16, 8, 4, 2, 1};

	sample_row_t dir_rows[20] = '{
		'{16'd100, 16'd100, 16'sd0, 1'b0},
		'{16'd100, 16'd100, 16'sd0, 1'b1},
		'{16'd120, 16'd120, 16'sd0, 1'b0},
		'{16'd130, 16'd110, 16'sd1000, 1'b0},
		'{16'd65535, 16'd65535, 16'sd0, 1'b0},
		'{16'd65535, 16'd65535, -16'sd32768, 1'b0},
		'{16'd10, 16'd5, 16'sd32767, 1'b0},
		'{16'd32777, 16'd32772, 16'sd0, 1'b0},
		'{16'd9, 16'd4, 16'sd0, 1'b0},
		'{16'd9, 16'd4, -16'sd32768, 1'b0},
		'{16'd0, 16'd0, 16'sd0, 1'b0},
		'{16'd0, 16'd100, 16'sd0, 1'b0},
		'{16'd100, 16'd0, 16'sd17999, 1'b0},
		'{16'hffff, 16'h8000, -16'sd17999, 1'b0},
		'{16'haaaa, 16'h5555, 16'sd9000, 1'b0},
		'{16'h5555, 16'haaaa, 16'sd0, 1'b0},
		'{16'h5555, 16'haaaa, -16'sd9000, 1'b0},
		'{16'h5560, 16'haab5, 16'sd0, 1'b0},
		'{16'h5560, 16'haab5, 16'sd0, 1'b0},
		'{16'h5570, 16'haac5, 16'sd100, 1'b0}
	};

	diff_drive_odometry_goto u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.enc_left(enc_left), .enc_right(enc_right), .gyro_angle(gyro_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.pos_x(pos_x), .pos_y(pos_y), .heading_error(heading_error),
		.command_kind(command_kind), .drive_speed(drive_speed),
		.turn_radius(turn_radius), .rotation_speed(rotation_speed),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Rotation-mode CORDIC with folding into +-pi/2
	function automatic void rotate_unit(input longint a, output longint s, output longint c);
		longint x, y, xs, ys;
		bit flip;
		x = 652032874;
		y = 0;
		flip = 0;
		while (a > 102944) begin a -= 205887; flip = !flip; end
		while (a < -102944) begin a += 205887; flip = !flip; end
		for (int i = 0; i < 17; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (a >= 0) begin
				x -= ys; y += xs; a -= atan_q[i];
			end else begin
				x += ys; y -= xs; a += atan_q[i];
			end
		end
		x = x >>> 14;
		y = y >>> 14;
		if (flip) begin x = -x; y = -y; end
		s = y;
		c = x;
	endfunction

	// Bearing to the goal; vectoring CORDIC after normalising the vector
	function automatic longint bearing_of(input longint dy, input longint dx);
		longint x, y, m, z, xs, ys;
		if (dx == 0)
			return (dy > 0) ? 64'sd102944 : -64'sd102944;
		x = (dx < 0) ? -dx : dx;
		y = (dx < 0) ? -dy : dy;
		m = (y < 0) ? -y : y;
		z = 0;
		if (x > m) m = x;
		while (m < (64'sd1 <<< 40)) begin x *= 2; y *= 2; m *= 2; end
		for (int i = 0; i < 17; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_q[i];
			end else begin
				x -= ys; y += xs; z -= atan_q[i];
			end
		end
		return z;
	endfunction

	// Advance odometry and controller for one word; returns 1 when a command results
	function automatic bit odo_advance(input logic [15:0] el, input logic [15:0] er,
			input logic signed [15:0] gy, output command_t cmd);
		logic [15:0] d16;
		longint dl, dr, l, r, diff, rads, sn, cn, sp, cp, sum, rad, half;
		longint dx, dy, fi, efi, afi, epos, aepos, trans;
		int ph;
		ph = phase_cnt;
		cmd = '{default: '0};
		if (!has_started) begin
			prev_left = el; prev_right = er; has_started = 1;
		end
		phase_cnt = (ph >= 4) ? 0 : ph + 1;
		if (ph == 0)
			return 0;
		d16 = el - prev_left;
		dl = longint'($signed(d16));
		d16 = er - prev_right;
		dr = longint'($signed(d16));
		prev_left = el;
		prev_right = er;
		l = (dl * tick_q32) >>> 16;
		r = (dr * tick_q32) >>> 16;
		rads = (longint'(gy) * 749613) >>> 16;
		rotate_unit(rads, sn, cn);
		diff = r - l;
		if (diff != 0) begin
			sum = clamp32(r + l);
			rad = clamp32((base_q16 * sum) / (2 * diff));
			rotate_unit(prev_head, sp, cp);
			odo_x = clamp32(odo_x + ((rad * (sn - sp)) >>> 16));
			odo_y = clamp32(odo_y - ((rad * (cn - cp)) >>> 16));
		end else begin
			half = (r + l) >>> 1;
			odo_x = clamp32(odo_x + ((half * cn) >>> 16));
			odo_y = clamp32(odo_y + ((half * sn) >>> 16));
		end
		prev_head = rads;
		dx = goal_x - odo_x;
		dy = goal_y - odo_y;
		fi = bearing_of(dy, dx);
		efi = fi - rads;
		afi = (efi < 0) ? -efi : efi;
		epos = dx + dy;
		aepos = (epos < 0) ? -epos : epos;
		trans = (speed_gain * epos + 15 * 65536) / 65536;
		if (afi >= 13107) is_aligned = 0;
		if (afi < 13107 && is_aligned) begin
			cmd.kind = 1'b0;
			if (aepos < 655) trans = 0;
			if (trans > 500) trans = 500;
			if (trans < -32768) trans = -32768;
			cmd.speed = trans[15:0];
			if (afi < 655)
				cmd.radius = 7'sd0;
			else
				cmd.radius = (efi > 0) ? ARC_RADIUS : -ARC_RADIUS;
		end else begin
			cmd.kind = 1'b1;
			cmd.rot = clamp32(rot_gain * efi + 6554);
			if (afi < 655) is_aligned = 1;
		end
		cmd.px = odo_x[31:0];
		cmd.py = odo_y[31:0];
		cmd.herr = clamp32(efi);
		return 1;
	endfunction

	function automatic void reg_apply(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
		case (idx)
			REG_TARGET_X:   goal_x = longint'($signed(v));
			REG_TARGET_Y:   goal_y = longint'($signed(v));
			REG_TICK_SCALE: tick_q32 = longint'(v);
			REG_WHEEL_BASE: base_q16 = longint'(v);
			REG_DRIVE_GAIN: speed_gain = longint'(v[15:0]);
			REG_TURN_GAIN:  rot_gain = longint'(v[15:0]);
			default: ;
		endcase
	endfunction

	// Offer one word after the current gap, hold it until taken, then predict
	task automatic send_word(input logic [15:0] el, input logic [15:0] er,
			input logic signed [15:0] gy, input bit at_origin);
		command_t cmd;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
		end
		if (gap_left > 0) begin
			in_valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		burst_left--;
		in_valid <= 1'b1;
		enc_left <= el;
		enc_right <= er;
		gyro_angle <= gy;
		do @(posedge clk); while (!in_ready);
		if (odo_advance(el, er, gy, cmd)) begin
			if (at_origin && (cmd.px != 0 || cmd.py != 0)) begin
				$display("%0t origin: expected 0/0 actual %0d/%0d", $time, cmd.px, cmd.py);
				errors++;
			end
			pending_cmds.push_back(cmd);
		end
	endtask

	// Drain, let any skipped word finish, then write one register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (PAUSE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_apply(idx, v);
	endtask

	task automatic write_all(input logic [31:0] tx, input logic [31:0] ty,
			input logic [31:0] ts, input logic [31:0] wb,
			input logic [31:0] dg, input logic [31:0] tg);
		write_reg(REG_TARGET_X, tx);
		write_reg(REG_TARGET_Y, ty);
		write_reg(REG_TICK_SCALE, ts);
		write_reg(REG_WHEEL_BASE, wb);
		write_reg(REG_DRIVE_GAIN, dg);
		write_reg(REG_TURN_GAIN, tg);
	endtask

	// Random walk: mostly heading towards the goal with small wheel steps, some noise
	task automatic walk(input int count, input int step_max);
		longint fi, g;
		int dl;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				walk_l = $urandom;
				walk_r = $urandom;
				g = $signed(16'($urandom));
			end else begin
				dl = $urandom_range(0, 2 * step_max) - step_max / 4;
				walk_l = walk_l + 16'(dl);
				walk_r = ($urandom_range(0, 1) == 0) ? walk_l : walk_r + 16'(dl
					+ $urandom_range(0, 6) - 3);
				if ($urandom_range(0, 1) == 0)
					walk_r = walk_r - walk_l + walk_l;
				fi = bearing_of(goal_y - odo_y, goal_x - odo_x);
				g = ((fi * 5730) >>> 16) + int'($urandom_range(0, 160)) - 80;
				if ($urandom_range(0, 7) == 0)
					g = g + int'($urandom_range(0, 4000)) - 2000;
				if (g > 32767) g = 32767;
				if (g < -32768) g = -32768;
			end
			send_word(walk_l, walk_r, g[15:0], 1'b0);
		end
	endtask

	// Result checks
	function automatic void cmp(input string nm, input longint e, input longint a);
		if (e != a) begin
			$display("%0t %s: expected %0d actual %0d", $time, nm, e, a);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		command_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t unexpected word: expected none actual pos %0d/%0d", $time,
					pos_x, pos_y);
				errors++;
			end else begin
				e = pending_cmds.pop_front();
				cmp("pos_x", e.px, pos_x);
				cmp("pos_y", e.py, pos_y);
				cmp("heading_error", e.herr, heading_error);
				cmp("command_kind", e.kind, command_kind);
				cmp("drive_speed", e.speed, drive_speed);
				cmp("turn_radius", e.radius, turn_radius);
				cmp("rotation_speed", e.rot, rotation_speed);
			end
		end
	end

	// Receiver: stall pattern redrawn periodically from four modes, one long hold-off
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 6000) begin
				out_ready <= 1'b0;
				repeat (4000) @(posedge clk);
			end
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= cyc[2];
			endcase
		end
	end

	initial begin
		#60ms;
		$display("tb: failure");
		$finish;
	end

	// Main sequence
	initial begin
		in_valid <= 1'b0;
		enc_left <= '0;
		enc_right <= '0;
		gyro_angle <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		goal_x = 26214; goal_y = 0; tick_q32 = 365072; base_q16 = 15073;
		speed_gain = 500; rot_gain = 1;
		prev_left = 0; prev_right = 0; prev_head = 0; odo_x = 0; odo_y = 0;
		is_aligned = 0; has_started = 0; phase_cnt = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].el, dir_rows[i].er, dir_rows[i].gy, dir_rows[i].at_origin);
		walk_l = 16'h5570;
		walk_r = 16'haac5;

		write_all(32'h0004_0000, 32'hfffe_0000, 32'd2920576, 32'd15073, 32'd500, 32'd1);
		walk(300, 200);
		write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'h0000_ffff, 32'h0000_ffff);
		walk(150, 30000);
		write_all(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0);
		walk(150, 500);
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		write_all($urandom_range(0, 524288) - 262144, $urandom_range(0, 524288) - 262144,
			$urandom_range(1 << 20, 1 << 24), $urandom_range(10000, 40000),
			$urandom_range(0, 65535), $urandom_range(1, 8));
		walk(400, 100);
		write_all(32'd26214, 32'd0, 32'd365072, 32'd15073, 32'd500, 32'd1);
		walk(500, 60);

		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (PAUSE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: files.f
rtl/core/ddo_pkg.sv
rtl/core/ddo_mul.sv
rtl/core/ddo_div.sv
rtl/core/ddo_cordic.sv
rtl/core/diff_drive_odometry_goto.sv
rtl/core/ddo_checker.sv
tb/sv/tb_diff_drive_odometry_goto.sv
